// File: rtl/sfrsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame receiver package
// Shared constants and the result record of the frame receiver.
// ----------------------------------------------------------------------------
package sfrsd_pkg;

    localparam int RX_W    = 8;
    localparam int POS_W   = 17;
    localparam int LEN_W   = 16;
    localparam int TDATA_W = 32;

    localparam logic [7:0] HDR_FIRST      = 8'h55;
    localparam logic [7:0] HDR_SECOND     = 8'hAA;
    localparam logic [7:0] CMD_STATUS     = 8'h07;
    localparam logic [7:0] CMD_TIME       = 8'h1C;
    localparam logic [7:0] DP_POWER       = 8'h01;
    localparam logic [7:0] DP_SETPOINT    = 8'h02;
    localparam logic [7:0] DP_TEMPERATURE = 8'h03;
    localparam logic [7:0] DP_HEATING     = 8'h0E;
    localparam logic [7:0] HEAT_ON_VAL    = 8'h00;
    localparam logic [7:0] HEAT_OFF_VAL   = 8'h01;

    localparam logic [7:0] SETPOINT_RESET = 8'd18;
    localparam logic [7:0] TEMP_UNKNOWN   = 8'd128;

    typedef logic [POS_W-1:0] pos_t;

    localparam pos_t POS_HUNT   = 17'd0;
    localparam pos_t POS_HDR2   = 17'd1;
    localparam pos_t POS_BODY   = 17'd2;
    localparam pos_t POS_CMD    = 17'd3;
    localparam pos_t POS_LEN_HI = 17'd4;
    localparam pos_t POS_LEN_LO = 17'd5;
    localparam pos_t POS_DP     = 17'd6;
    localparam pos_t POS_B10    = 17'd10;
    localparam pos_t POS_B13    = 17'd13;

    typedef struct packed {
        logic       request_time_send;
        logic       request_power_on;
        logic [7:0] room_temperature;
        logic [7:0] room_setpoint;
        logic       heating_active;
        logic       device_is_on;
        logic [7:0] command_code;
        logic       frame_status;
    } result_t;

endpackage

// File: rtl/sfrsd_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input register
// Holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module sfrsd_in_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [sfrsd_pkg::RX_W-1:0] s_tdata,
    input  logic                  take,
    output logic                  byte_valid,
    output logic [sfrsd_pkg::RX_W-1:0] byte_data
);
    import sfrsd_pkg::*;

    logic            valid_reg;
    logic            valid_next;
    logic [RX_W-1:0] data_reg;
    logic [RX_W-1:0] data_next;

    assign s_tready   = !valid_reg || take;
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
            data_next  = s_tdata;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

endmodule

// File: rtl/sfrsd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser and status decoder
// Tracks the frame position, length and running sum, and applies status
// reports when a checksum byte with a matching sum arrives.
// ----------------------------------------------------------------------------
module sfrsd_parser (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       fire,
    input  logic [sfrsd_pkg::RX_W-1:0] rx_byte,
    input  logic                       keep_device_on,
    output logic                       res_valid,
    output sfrsd_pkg::result_t         res
);
    import sfrsd_pkg::*;

    pos_t             pos_reg,   pos_next;
    logic [LEN_W-1:0] len_reg,   len_next;
    logic [7:0]       sum_reg,   sum_next;
    logic [7:0]       cmd_reg,   cmd_next;
    logic [7:0]       dp_reg,    dp_next;
    logic [7:0]       b10_reg,   b10_next;
    logic [7:0]       b13_reg,   b13_next;
    logic             power_reg, power_next;
    logic             sent_reg,  sent_next;
    logic             heat_reg,  heat_next;
    logic [7:0]       setp_reg,  setp_next;
    logic [7:0]       temp_reg,  temp_next;

    logic       is_ck;
    logic       good;
    logic [7:0] dp_eff;
    logic [7:0] b10_eff;
    logic [7:0] b13_eff;
    logic       req_on;
    logic       req_time;

    assign is_ck = (pos_reg >= POS_DP) && (pos_reg == POS_DP + {1'b0, len_reg});
    assign good  = (rx_byte == sum_reg);

    // The checksum byte itself may land on a captured offset in a short frame.
    assign dp_eff  = (pos_reg == POS_DP)  ? rx_byte : dp_reg;
    assign b10_eff = (pos_reg == POS_B10) ? rx_byte : b10_reg;
    assign b13_eff = (pos_reg == POS_B13) ? rx_byte : b13_reg;

    always_comb begin
        power_next = power_reg;
        sent_next  = sent_reg;
        heat_next  = heat_reg;
        setp_next  = setp_reg;
        temp_next  = temp_reg;
        req_on     = 1'b0;
        req_time   = 1'b0;
        if (is_ck && good) begin
            if (cmd_reg == CMD_STATUS) begin
                unique case (dp_eff)
                    DP_POWER: begin
                        power_next = (b10_eff != 8'd0);
                        if (!power_next) begin
                            if (!sent_reg || keep_device_on) begin
                                req_on    = 1'b1;
                                sent_next = 1'b1;
                            end
                            heat_next = 1'b0;
                        end
                    end
                    DP_SETPOINT:    setp_next = b13_eff;
                    DP_TEMPERATURE: temp_next = b13_eff;
                    DP_HEATING: begin
                        if (b10_eff == HEAT_ON_VAL) begin
                            heat_next = power_reg;
                        end else if (b10_eff == HEAT_OFF_VAL) begin
                            heat_next = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end else if (cmd_reg == CMD_TIME) begin
                req_time = 1'b1;
            end
        end
    end

    always_comb begin
        pos_next = pos_reg;
        len_next = len_reg;
        sum_next = sum_reg;
        cmd_next = cmd_reg;
        dp_next  = dp_reg;
        b10_next = b10_reg;
        b13_next = b13_reg;
        if (pos_reg == POS_HUNT) begin
            if (rx_byte == HDR_FIRST) begin
                cmd_next = 8'd0;
                dp_next  = 8'd0;
                b10_next = 8'd0;
                b13_next = 8'd0;
                len_next = '0;
                sum_next = rx_byte;
                pos_next = POS_HDR2;
            end
        end else if (pos_reg == POS_HDR2) begin
            if (rx_byte == HDR_SECOND) begin
                sum_next = sum_reg + rx_byte;
                pos_next = POS_BODY;
            end else begin
                pos_next = POS_HUNT;
            end
        end else begin
            if (pos_reg == POS_CMD) cmd_next = rx_byte;
            dp_next  = dp_eff;
            b10_next = b10_eff;
            b13_next = b13_eff;
            if (is_ck) begin
                pos_next = POS_HUNT;
            end else begin
                if (pos_reg == POS_LEN_HI) len_next = {rx_byte, 8'h00};
                if (pos_reg == POS_LEN_LO) len_next = {len_reg[LEN_W-1:8], rx_byte};
                sum_next = sum_reg + rx_byte;
                pos_next = pos_reg + POS_HDR2;
            end
        end
    end

    assign res_valid             = is_ck;
    assign res.frame_status      = !good;
    assign res.command_code      = cmd_reg;
    assign res.device_is_on      = power_next;
    assign res.heating_active    = heat_next;
    assign res.room_setpoint     = setp_next;
    assign res.room_temperature  = temp_next;
    assign res.request_power_on  = req_on;
    assign res.request_time_send = req_time;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= POS_HUNT;
            len_reg   <= '0;
            sum_reg   <= 8'd0;
            cmd_reg   <= 8'd0;
            dp_reg    <= 8'd0;
            b10_reg   <= 8'd0;
            b13_reg   <= 8'd0;
            power_reg <= 1'b0;
            sent_reg  <= 1'b0;
            heat_reg  <= 1'b0;
            setp_reg  <= SETPOINT_RESET;
            temp_reg  <= TEMP_UNKNOWN;
        end else if (fire) begin
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            sum_reg   <= sum_next;
            cmd_reg   <= cmd_next;
            dp_reg    <= dp_next;
            b10_reg   <= b10_next;
            b13_reg   <= b13_next;
            power_reg <= power_next;
            sent_reg  <= sent_next;
            heat_reg  <= heat_next;
            setp_reg  <= setp_next;
            temp_reg  <= temp_next;
        end
    end

endmodule

// File: rtl/sfrsd_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result register
// Holds one frame result until the downstream side takes it.
// ----------------------------------------------------------------------------
module sfrsd_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  logic               res_valid,
    input  sfrsd_pkg::result_t res,
    output logic               out_ready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output sfrsd_pkg::result_t m_res
);
    import sfrsd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;
    result_t res_next;

    assign out_ready = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_res     = res_reg;

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (out_ready) begin
            valid_next = fire && res_valid;
            res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        res_reg <= res_next;
    end

endmodule

// File: rtl/serial_frame_receiver_status_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame receiver and status decoder
// Assembles 0x55 0xAA framed messages from received bytes, checks the
// checksum and decodes device status reports into one result per frame.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transfer contents
//  s_axis    in         one received byte per transfer
//  m_axis    out        one result per finished frame
//  cfg       in         keep-on flag, written with cfg_wr_en
//
// One byte is accepted every cycle while no result is stalled; m_tvalid for a
// frame rises once its checksum byte has passed from the input register
// through the single parser stage into the result register.
// Reset is synchronous and active low, resets the frame position and the
// device status and clears both valid flags; keep-on resets to one.
// A stalled result holds its register and the input register fills, after
// which s_tready falls until the result is taken.
// ----------------------------------------------------------------------------
module serial_frame_receiver_status_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] frame_status, [8:1] command_code, [9] device_is_on,
    // [10] heating_active, [18:11] room_setpoint, [26:19] room_temperature,
    // [27] request_power_on, [28] request_time_send, [31:29] zero
    output logic [31:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data
);
    import sfrsd_pkg::*;

    logic            keep_on_reg;
    logic            take;
    logic            out_ready;
    logic            byte_valid;
    logic [RX_W-1:0] byte_data;
    logic            res_valid;
    result_t         res;
    result_t         m_res;

    assign take = byte_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_on_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            keep_on_reg <= cfg_wr_data;
        end
    end

    sfrsd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (take),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    sfrsd_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .fire           (take),
        .rx_byte        (byte_data),
        .keep_device_on (keep_on_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    sfrsd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (take),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (m_res)
    );

    assign m_tdata = {3'b000, m_res};

endmodule

// File: rtl/sfrsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver port checker
// Checks result consistency and the result handshake at the top-level ports.
// ----------------------------------------------------------------------------
module sfrsd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    import sfrsd_pkg::*;

    // Results cannot survive a reset.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A power-on request only follows a good frame reporting the device off.
    a_power_req: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[27] |-> !m_tdata[0] && !m_tdata[9] && !m_tdata[10])
        else $error("power-on request on an inconsistent result");

    // A time request only follows a good time command frame.
    a_time_req: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[28] |-> !m_tdata[0] && (m_tdata[8:1] == CMD_TIME))
        else $error("time request on an inconsistent result");

    // Heating is never shown while the device is off.
    a_heat_on: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10] |-> m_tdata[9])
        else $error("heating active with device off");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result transfer changed");

endmodule

bind serial_frame_receiver_status_decoder sfrsd_checker u_sfrsd_checker (.*);

// File: tb/sv/serial_frame_receiver_status_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame receiver and status decoder testbench
// Drives received bytes into the parser and predicts each frame result from
// its own model of the framing, checksum and status decoding. Directed tests
// cover header hunting, short and zero-length frames, checksum errors, every
// status report and the keep-on register. Random framed traffic with noise
// follows, under changing back-pressure on both channels.
// ----------------------------------------------------------------------------
module serial_frame_receiver_status_decoder_tb;
    import sfrsd_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 8;
    localparam int REPORT_MAX  = 10;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'h00;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;

    // Model of the parser and the device status.
    pos_t        frame_pos;
    logic [15:0] pay_len;
    logic [7:0]  sum_acc;
    logic [7:0]  cap_cmd;
    logic [7:0]  cap_dp;
    logic [7:0]  cap_b10;
    logic [7:0]  cap_b13;
    logic        dev_on;
    logic        on_req_sent;
    logic        heat_on;
    logic [7:0]  setpoint;
    logic [7:0]  room_temp;
    logic        keep_on;

    result_t     expected_frames[$];
    result_t     frame_got;
    result_t     frame_exp;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          rx_bytes_sent  = 0;
    int          tx_idle_pct    = 0;
    int          rx_idle_pct    = 0;

    serial_frame_receiver_status_decoder uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("serial_frame_receiver_status_decoder_tb: done, errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            frame_got = m_tdata[$bits(result_t)-1:0];
            if (expected_frames.size() == 0) begin
                if (mismatch_count < REPORT_MAX) begin
                    $display("unexpected frame result, tdata %08h", m_tdata);
                end
                mismatch_count++;
            end else begin
                frame_exp = expected_frames.pop_front();
                if (frame_got.frame_status !== frame_exp.frame_status ||
                    frame_got.command_code !== frame_exp.command_code ||
                    frame_got.device_is_on !== frame_exp.device_is_on ||
                    frame_got.heating_active !== frame_exp.heating_active ||
                    frame_got.room_setpoint !== frame_exp.room_setpoint ||
                    frame_got.room_temperature !== frame_exp.room_temperature ||
                    frame_got.request_power_on !== frame_exp.request_power_on ||
                    frame_got.request_time_send !== frame_exp.request_time_send) begin
                    if (mismatch_count < REPORT_MAX) begin
                        $display("frame result mismatch at %0t", $realtime);
                        $display("  exp st %0d cmd %02h on %0d ht %0d sp %02h tp %02h rq %0d%0d",
                                 frame_exp.frame_status, frame_exp.command_code,
                                 frame_exp.device_is_on, frame_exp.heating_active,
                                 frame_exp.room_setpoint, frame_exp.room_temperature,
                                 frame_exp.request_power_on, frame_exp.request_time_send);
                        $display("  act st %0d cmd %02h on %0d ht %0d sp %02h tp %02h rq %0d%0d",
                                 frame_got.frame_status, frame_got.command_code,
                                 frame_got.device_is_on, frame_got.heating_active,
                                 frame_got.room_setpoint, frame_got.room_temperature,
                                 frame_got.request_power_on, frame_got.request_time_send);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    task automatic reset_model();
        frame_pos   = POS_HUNT;
        pay_len     = '0;
        sum_acc     = '0;
        cap_cmd     = '0;
        cap_dp      = '0;
        cap_b10     = '0;
        cap_b13     = '0;
        dev_on      = 1'b0;
        on_req_sent = 1'b0;
        heat_on     = 1'b0;
        setpoint    = SETPOINT_RESET;
        room_temp   = TEMP_UNKNOWN;
        keep_on     = 1'b1;
    endtask

    task automatic decode_rx_byte(input logic [7:0] b);
        pos_t    p;
        result_t r;
        logic    chk_bad;
        p = frame_pos;
        r = '0;
        if (p == POS_HUNT) begin
            if (b == HDR_FIRST) begin
                cap_cmd   = '0;
                cap_dp    = '0;
                cap_b10   = '0;
                cap_b13   = '0;
                pay_len   = '0;
                sum_acc   = b;
                frame_pos = POS_HDR2;
            end
        end else if (p == POS_HDR2) begin
            if (b == HDR_SECOND) begin
                sum_acc   = sum_acc + b;
                frame_pos = POS_BODY;
            end else begin
                frame_pos = POS_HUNT;
            end
        end else begin
            if (p == POS_CMD) cap_cmd = b;
            if (p == POS_DP)  cap_dp  = b;
            if (p == POS_B10) cap_b10 = b;
            if (p == POS_B13) cap_b13 = b;
            if (p < POS_DP || p != POS_DP + pos_t'(pay_len)) begin
                if (p == POS_LEN_HI) pay_len = {b, 8'h00};
                if (p == POS_LEN_LO) pay_len[7:0] = b;
                sum_acc   = sum_acc + b;
                frame_pos = p + 1'b1;
            end else begin
                chk_bad   = (b != sum_acc);
                frame_pos = POS_HUNT;
                if (!chk_bad) begin
                    if (cap_cmd == CMD_STATUS) begin
                        case (cap_dp)
                            DP_POWER: begin
                                dev_on = (cap_b10 != 8'h00);
                                if (!dev_on) begin
                                    if (!on_req_sent || keep_on) begin
                                        r.request_power_on = 1'b1;
                                        on_req_sent        = 1'b1;
                                    end
                                    heat_on = 1'b0;
                                end
                            end
                            DP_SETPOINT:    setpoint  = cap_b13;
                            DP_TEMPERATURE: room_temp = cap_b13;
                            DP_HEATING: begin
                                if (cap_b10 == HEAT_ON_VAL) begin
                                    heat_on = dev_on;
                                end else if (cap_b10 == HEAT_OFF_VAL) begin
                                    heat_on = 1'b0;
                                end
                            end
                            default: ;
                        endcase
                    end else if (cap_cmd == CMD_TIME) begin
                        r.request_time_send = 1'b1;
                    end
                end
                r.frame_status     = chk_bad;
                r.command_code     = cap_cmd;
                r.device_is_on     = dev_on;
                r.heating_active   = heat_on;
                r.room_setpoint    = setpoint;
                r.room_temperature = room_temp;
                expected_frames.push_back(r);
            end
        end
    endtask

    task automatic send_rx_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        decode_rx_byte(b);
        rx_bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len,
                              input logic [7:0] dp, input logic [7:0] b10,
                              input logic [7:0] b13, input bit corrupt);
        logic [7:0] frame_q[$];
        logic [7:0] sum;
        int         i;
        frame_q = {HDR_FIRST, HDR_SECOND, 8'($urandom_range(0, 255)), cmd,
                   len[15:8], len[7:0]};
        for (i = 0; i < int'(len); i++) frame_q.push_back(8'($urandom_range(0, 255)));
        if (len > 0) frame_q[6] = dp;
        if (len > 4) frame_q[10] = b10;
        if (len > 7) frame_q[13] = b13;
        sum = '0;
        foreach (frame_q[k]) sum = sum + frame_q[k];
        if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
        frame_q.push_back(sum);
        foreach (frame_q[k]) send_rx_byte(frame_q[k]);
    endtask

    task automatic drain_frames();
        s_tvalid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_keep_on(input logic v);
        drain_frames();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        keep_on = v;
    endtask

    task automatic set_idle(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    task automatic test_header_hunt();
        send_rx_byte(8'h00);
        send_rx_byte(8'hFF);
        send_rx_byte(HDR_SECOND);
        send_rx_byte(HDR_FIRST);
        send_rx_byte(8'h13);
        send_rx_byte(HDR_FIRST);
        send_rx_byte(HDR_FIRST);
        send_rx_byte(HDR_SECOND);
        send_frame(8'h00, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0);
    endtask

    task automatic test_zero_length();
        send_frame(CMD_STATUS, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0);
        send_frame(8'hFF, 16'd0, 8'h00, 8'h00, 8'h00, 1'b1);
    endtask

    task automatic test_checksum_error();
        send_frame(CMD_STATUS, 16'd8, DP_SETPOINT, 8'h00, 8'h33, 1'b1);
        send_frame(CMD_TIME, 16'd2, 8'h00, 8'h00, 8'h00, 1'b1);
    endtask

    task automatic test_status_reports();
        send_frame(CMD_STATUS, 16'd8, DP_POWER, 8'h01, 8'h00, 1'b0);
        send_frame(CMD_STATUS, 16'd8, DP_HEATING, HEAT_ON_VAL, 8'h00, 1'b0);
        send_frame(CMD_STATUS, 16'd8, DP_SETPOINT, 8'h00, 8'hFF, 1'b0);
        send_frame(CMD_STATUS, 16'd8, DP_TEMPERATURE, 8'h00, 8'h00, 1'b0);
        send_frame(CMD_STATUS, 16'd8, DP_HEATING, HEAT_OFF_VAL, 8'h00, 1'b0);
        send_frame(CMD_STATUS, 16'd8, DP_HEATING, 8'h02, 8'h00, 1'b0);
        send_frame(CMD_STATUS, 16'd8, DP_HEATING, HEAT_ON_VAL, 8'h00, 1'b0);
        send_frame(CMD_STATUS, 16'd8, DP_POWER, 8'h00, 8'h00, 1'b0);
        send_frame(CMD_STATUS, 16'd8, 8'h05, 8'h01, 8'h44, 1'b0);
    endtask

    task automatic test_time_request();
        send_frame(CMD_TIME, 16'd3, 8'h00, 8'h00, 8'h00, 1'b0);
        send_frame(CMD_TIME, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0);
    endtask

    task automatic test_keep_on();
        write_keep_on(1'b0);
        send_frame(CMD_STATUS, 16'd8, DP_POWER, 8'h00, 8'h00, 1'b0);
        send_frame(CMD_STATUS, 16'd8, DP_POWER, 8'h80, 8'h00, 1'b0);
        send_frame(CMD_STATUS, 16'd8, DP_POWER, 8'h00, 8'h00, 1'b0);
        write_keep_on(1'b1);
        send_frame(CMD_STATUS, 16'd8, DP_POWER, 8'h00, 8'h00, 1'b0);
        send_frame(CMD_STATUS, 16'd8, DP_HEATING, HEAT_ON_VAL, 8'h00, 1'b0);
    endtask

    task automatic test_short_frames();
        send_frame(CMD_STATUS, 16'd1, DP_POWER, 8'h00, 8'h00, 1'b0);
        send_frame(CMD_STATUS, 16'd3, DP_HEATING, 8'h00, 8'h00, 1'b0);
        send_frame(CMD_STATUS, 16'd4, DP_HEATING, 8'h00, 8'h00, 1'b0);
        send_frame(CMD_STATUS, 16'd7, DP_SETPOINT, 8'h00, 8'h00, 1'b0);
        send_frame(CMD_STATUS, 16'd7, DP_TEMPERATURE, 8'h00, 8'h00, 1'b0);
    endtask

    task automatic test_length_extremes();
        send_frame(CMD_STATUS, 16'h0100, DP_SETPOINT, 8'h00, 8'h2A, 1'b0);
    endtask

    task automatic test_random_traffic(input int n_bytes);
        int          stop_at;
        int          pick;
        int          i;
        logic [7:0]  cmd;
        logic [7:0]  dp;
        logic [7:0]  b10;
        logic [15:0] len;
        stop_at = rx_bytes_sent + n_bytes;
        while (rx_bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                for (i = $urandom_range(1, 6); i > 0; i--) begin
                    send_rx_byte(8'($urandom_range(0, 255)));
                end
            end else if (pick < 13) begin
                send_rx_byte(HDR_FIRST);
                send_rx_byte(8'($urandom_range(0, 255)));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 65)      cmd = CMD_STATUS;
                else if (pick < 80) cmd = CMD_TIME;
                else                cmd = 8'($urandom_range(0, 255));
                case ($urandom_range(0, 4))
                    0:       dp = DP_POWER;
                    1:       dp = DP_SETPOINT;
                    2:       dp = DP_TEMPERATURE;
                    3:       dp = DP_HEATING;
                    default: dp = 8'($urandom_range(0, 255));
                endcase
                if ($urandom_range(0, 2) == 0) b10 = 8'($urandom_range(0, 255));
                else                           b10 = 8'($urandom_range(0, 1));
                pick = $urandom_range(0, 99);
                if (pick < 80)      len = 16'($urandom_range(8, 14));
                else if (pick < 95) len = 16'($urandom_range(0, 7));
                else                len = 16'($urandom_range(15, 48));
                send_frame(cmd, len, dp, b10, 8'($urandom_range(0, 255)),
                           $urandom_range(0, 99) < 12);
            end
        end
    endtask

    initial begin
        reset_model();
        set_idle(31, 51);
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_header_hunt();
        test_zero_length();
        test_checksum_error();
        test_status_reports();
        test_time_request();
        test_keep_on();
        test_short_frames();
        test_length_extremes();

        test_random_traffic(145);
        write_keep_on(1'b0);
        set_idle(51, 31);
        test_random_traffic(145);
        write_keep_on(1'b1);
        set_idle(0, 0);
        test_random_traffic(145);

        drain_frames();
        if (mismatch_count == 0) begin
            $display("serial_frame_receiver_status_decoder_tb: done, clean");
        end else begin
            $display("serial_frame_receiver_status_decoder_tb: done, errors");
        end
        $finish;
    end

endmodule
